// File: hdl/dhp_pkg.sv
// Shared types, constants and a helper function for the decimal hundredths parser.
package dhp_pkg;

   // Default digit limits; the top level hands these down as parameters.
   localparam int INTEGER_DIGITS_DEFAULT  = 8;
   localparam int FRACTION_DIGITS_DEFAULT = 2;

   // Fixed widths of the datapath.
   localparam int ACC_WIDTH    = 34;
   localparam int VALUE_WIDTH  = 35;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 4;
   localparam int PAD_WIDTH    = 3;
   localparam int SCALE_WIDTH  = 14;

   // Characters of interest.
   localparam logic [7:0] CHAR_TERM  = 8'h00;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Status codes of a result beat.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_MINUS = 2'd2;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_INT   = 3'd1,
      PH_FRAC  = 3'd2,
      PH_SKIP  = 3'd3,
      PH_ERROR = 3'd4
   } phase_type;

   // One parse step's result toward the output register.
   typedef struct packed {
      logic                          is_last;
      logic signed [VALUE_WIDTH-1:0] value_hundredths;
      logic [STATUS_WIDTH-1:0]       status;
   } step_result_type;

   // Power of ten used to pad missing fraction digits.
   function automatic logic [SCALE_WIDTH-1:0] pow10(input logic [PAD_WIDTH-1:0] n);
      logic [SCALE_WIDTH-1:0] p;
      unique case (n)
         3'd0:    p = 14'd1;
         3'd1:    p = 14'd10;
         3'd2:    p = 14'd100;
         3'd3:    p = 14'd1000;
         3'd4:    p = 14'd10000;
         default: p = 14'd1;
      endcase
      return p;
   endfunction

endpackage

// File: hdl/dhp_step.sv
// Parser state machine: holds the running parse and forms the result at the terminator.
module dhp_step #(
   parameter int INTEGER_DIGITS  = dhp_pkg::INTEGER_DIGITS_DEFAULT,
   parameter int FRACTION_DIGITS = dhp_pkg::FRACTION_DIGITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               text_byte,
   input  logic                     allow_negative,
   output dhp_pkg::step_result_type result
);

   dhp_pkg::phase_type                    phase_ff, phase_in;
   logic [dhp_pkg::ACC_WIDTH-1:0]         acc_ff, acc_in;
   logic [dhp_pkg::COUNT_WIDTH-1:0]       count_ff, count_in;
   logic                                  negative_ff, negative_in;
   logic [dhp_pkg::STATUS_WIDTH-1:0]      error_ff, error_in;

   dhp_pkg::phase_type                    work_phase;
   logic                                  is_digit;
   logic [3:0]                            digit_value;
   logic [dhp_pkg::ACC_WIDTH-1:0]         acc_step;
   logic [dhp_pkg::COUNT_WIDTH-1:0]       pad_full;
   logic [dhp_pkg::PAD_WIDTH-1:0]         pad;
   logic [dhp_pkg::ACC_WIDTH+dhp_pkg::SCALE_WIDTH-1:0] product;
   logic [dhp_pkg::VALUE_WIDTH-1:0]       magnitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dhp_pkg::PH_START;
         acc_ff      <= '0;
         count_ff    <= '0;
         negative_ff <= 1'b0;
         error_ff    <= dhp_pkg::STATUS_OK;
      end else if (advance) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         count_ff    <= count_in;
         negative_ff <= negative_in;
         error_ff    <= error_in;
      end
   end

   assign is_digit    = (text_byte >= dhp_pkg::CHAR_ZERO) && (text_byte <= dhp_pkg::CHAR_NINE);
   assign digit_value = 4'(text_byte - dhp_pkg::CHAR_ZERO);
   // Times ten plus the digit, as the sum of two shifts and the digit.
   assign acc_step    = dhp_pkg::ACC_WIDTH'((acc_ff << 3) + (acc_ff << 1)
                        + {{(dhp_pkg::ACC_WIDTH-4){1'b0}}, digit_value});

   // Once a fraction has started, only the missing fraction digits are padded.
   assign pad_full = dhp_pkg::COUNT_WIDTH'(FRACTION_DIGITS) - count_ff;
   always_comb begin
      if ((phase_ff == dhp_pkg::PH_FRAC) || (phase_ff == dhp_pkg::PH_SKIP)) begin
         if (count_ff < dhp_pkg::COUNT_WIDTH'(FRACTION_DIGITS)) begin
            pad = pad_full[dhp_pkg::PAD_WIDTH-1:0];
         end else begin
            pad = '0;
         end
      end else begin
         pad = dhp_pkg::PAD_WIDTH'(FRACTION_DIGITS);
      end
   end

   assign product   = acc_ff * dhp_pkg::pow10(pad);
   assign magnitude = {1'b0, product[dhp_pkg::ACC_WIDTH-1:0]};

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      negative_in = negative_ff;
      error_in    = error_ff;
      work_phase  = phase_ff;

      result.is_last          = 1'b0;
      result.value_hundredths = '0;
      result.status           = error_ff;

      if (text_byte == dhp_pkg::CHAR_TERM) begin
         result.is_last = 1'b1;
         if (error_ff == dhp_pkg::STATUS_OK) begin
            result.value_hundredths = negative_ff ? -$signed(magnitude) : $signed(magnitude);
         end
         phase_in    = dhp_pkg::PH_START;
         acc_in      = '0;
         count_in    = '0;
         negative_in = 1'b0;
         error_in    = dhp_pkg::STATUS_OK;
      end else if ((phase_ff == dhp_pkg::PH_START) && (text_byte == dhp_pkg::CHAR_MINUS)) begin
         if (allow_negative) begin
            negative_in = 1'b1;
            phase_in    = dhp_pkg::PH_INT;
         end else begin
            phase_in = dhp_pkg::PH_ERROR;
            error_in = dhp_pkg::STATUS_NO_MINUS;
         end
      end else begin
         if (phase_ff == dhp_pkg::PH_START) begin
            work_phase = dhp_pkg::PH_INT;
            phase_in   = dhp_pkg::PH_INT;
         end
         unique case (work_phase)
            dhp_pkg::PH_INT: begin
               if (text_byte == dhp_pkg::CHAR_POINT) begin
                  phase_in = dhp_pkg::PH_FRAC;
                  count_in = '0;
               end else if (count_ff >= dhp_pkg::COUNT_WIDTH'(INTEGER_DIGITS)) begin
                  phase_in = dhp_pkg::PH_SKIP;
                  count_in = '0;
               end else if (is_digit) begin
                  acc_in   = acc_step;
                  count_in = count_ff + 1'b1;
               end else begin
                  phase_in = dhp_pkg::PH_ERROR;
                  error_in = dhp_pkg::STATUS_BAD_CHAR;
               end
            end
            dhp_pkg::PH_FRAC: begin
               if (count_ff >= dhp_pkg::COUNT_WIDTH'(FRACTION_DIGITS)) begin
                  phase_in = dhp_pkg::PH_SKIP;
               end else if (is_digit) begin
                  acc_in   = acc_step;
                  count_in = count_ff + 1'b1;
               end else begin
                  phase_in = dhp_pkg::PH_ERROR;
                  error_in = dhp_pkg::STATUS_BAD_CHAR;
               end
            end
            default: begin
               // Skipping or errored: the byte is ignored.
            end
         endcase
      end
   end

endmodule

// File: hdl/decimal_hundredths_parser.sv
// Top level of the decimal hundredths parser: input register, parse step and result register.
//
//   channel   ports                               direction   beat carries
//   request   req_valid, req_stall                in          one text byte, zero ends the text
//   response  rsp_valid, rsp_stall                out         value in hundredths and status
//   config    csr_write_enable, csr_write_data    in          the allow_negative bit
//
// One byte is taken per cycle while req_stall is low. A byte waits in the input register,
// and the terminator's result is loaded from there into the result register, where it
// is offered until its beat is taken. The parse state update closes on itself.
// Reset is synchronous and active high; it empties both registers, restarts the parse
// and sets allow_negative to one.
// A stalled result only holds up the input register when the byte waiting there is a
// terminator; other bytes keep flowing while a result waits to be taken.
module decimal_hundredths_parser #(
   parameter int INTEGER_DIGITS  = dhp_pkg::INTEGER_DIGITS_DEFAULT,
   parameter int FRACTION_DIGITS = dhp_pkg::FRACTION_DIGITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_text_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [dhp_pkg::VALUE_WIDTH-1:0] rsp_value_hundredths,
   output logic [dhp_pkg::STATUS_WIDTH-1:0]       rsp_status,
   input  logic                                   csr_write_enable,
   input  logic                                   csr_write_data
);

   logic                                   allow_negative_ff;
   logic                                   in_valid_ff;
   logic [7:0]                             in_byte_ff;
   logic                                   out_valid_ff;
   logic signed [dhp_pkg::VALUE_WIDTH-1:0] out_value_ff;
   logic [dhp_pkg::STATUS_WIDTH-1:0]       out_status_ff;

   logic                                   out_free;
   logic                                   advance;
   dhp_pkg::step_result_type               step_result;

   // The configuration bit is written directly; it is read when a byte is parsed.
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_negative_ff <= 1'b1;
      end else if (csr_write_enable) begin
         allow_negative_ff <= csr_write_data;
      end
   end

   // The result register can take a new beat when it is empty or being drained.
   assign out_free = !out_valid_ff || !rsp_stall;
   // The byte in the input register moves on unless it needs a full result register.
   assign advance   = in_valid_ff && (!step_result.is_last || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_text_byte;
      end
   end

   dhp_step #(
      .INTEGER_DIGITS  (INTEGER_DIGITS),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .text_byte      (in_byte_ff),
      .allow_negative (allow_negative_ff),
      .result         (step_result)
   );

   // Result register: loaded by a terminator, cleared once its beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_result.is_last) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.is_last) begin
         out_value_ff  <= step_result.value_hundredths;
         out_status_ff <= step_result.status;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_value_hundredths = out_value_ff;
   assign rsp_status           = out_status_ff;

endmodule

// File: tb/sv/tb_decimal_hundredths_parser.sv
// Self-checking testbench for the decimal hundredths parser: directed texts, then random texts.
module tb_decimal_hundredths_parser;
   timeunit 1ns;
   timeprecision 1ps;

   // The block is built with its default digit limits, so the predictor uses the same ones.
   localparam int INT_LIMIT  = dhp_pkg::INTEGER_DIGITS_DEFAULT;
   localparam int FRAC_LIMIT = dhp_pkg::FRACTION_DIGITS_DEFAULT;

   // A result leaves through the input and result registers after its terminator beat;
   // the settle cycles leave margin for bytes that yield no result but sit in the input register.
   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int MAX_GAP          = 18;
   localparam int PHASE_BYTES      = 220;
   localparam int LIMIT_CYCLES     = 400000;
   localparam int TEXT_CHARS       = 12;

   // One parse outcome: the value in hundredths and its status.
   typedef struct packed {
      logic signed [dhp_pkg::VALUE_WIDTH-1:0] value;
      logic [dhp_pkg::STATUS_WIDTH-1:0]       status;
   } parse_result_type;

   // A directed text. The string sits right-justified in the packed field, so the first
   // character is the highest nonzero byte. Where typed is set, the expected result is
   // taken from the row; otherwise the predictor decides it.
   typedef struct packed {
      bit [8*TEXT_CHARS-1:0]                  text;
      bit                                     allow_minus;
      bit                                     typed;
      logic signed [dhp_pkg::VALUE_WIDTH-1:0] value;
      logic [dhp_pkg::STATUS_WIDTH-1:0]       status;
   } text_case_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic [7:0]                             req_text_byte = 8'h00;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [dhp_pkg::VALUE_WIDTH-1:0] rsp_value_hundredths;
   logic [dhp_pkg::STATUS_WIDTH-1:0]       rsp_status;
   logic                                   csr_write_enable = 1'b0;
   logic                                   csr_write_data = 1'b0;

   decimal_hundredths_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_value_hundredths (rsp_value_hundredths),
      .rsp_status           (rsp_status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: a private copy of the parse registers and of allow_negative.
   dhp_pkg::phase_type               p_phase    = dhp_pkg::PH_START;
   logic [dhp_pkg::ACC_WIDTH-1:0]    p_acc      = '0;
   logic [dhp_pkg::COUNT_WIDTH-1:0]  p_count    = '0;
   logic                             p_negative = 1'b0;
   logic [dhp_pkg::STATUS_WIDTH-1:0] p_error    = dhp_pkg::STATUS_OK;
   logic                             negatives_allowed = 1'b1;

   // Results still owed by the block, oldest first.
   parse_result_type pending_results[$];

   // Bytes of the text about to be sent, terminator included where there is one.
   logic [7:0] text_bytes[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned sent_bytes     = 0;

   // Sender pacing: calm means back-to-back beats, rush forces them during the long hold.
   bit tx_calm = 1'b0;
   bit tx_rush = 1'b0;

   // Receiver pacing. The main process raises hold_requests; the receiver serves each one
   // with a long stall counted in its own process.
   bit          sink_calm     = 1'b0;
   int unsigned sink_wait     = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served  = 0;

   // Directed texts: empty and lone signs, extremes of the value, each error code, both
   // digit limits, bytes with the top bit set, and both settings of allow_negative.
   text_case_type directed_cases [27] = '{
      '{"",             1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"-",            1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_OK},
      '{".",            1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"0",            1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"5",            1'b1, 1'b1, 35'sd500,         dhp_pkg::STATUS_OK},
      '{"1.5",          1'b1, 1'b1, 35'sd150,         dhp_pkg::STATUS_OK},
      '{"12.34",        1'b1, 1'b1, 35'sd1234,        dhp_pkg::STATUS_OK},
      '{"99999999.99",  1'b1, 1'b1, 35'sd9999999999,  dhp_pkg::STATUS_OK},
      '{"-99999999.99", 1'b1, 1'b1, -35'sd9999999999, dhp_pkg::STATUS_OK},
      '{"12a",          1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"1-2",          1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"..",           1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"1.2x",         1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"4\377",        1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"\200",         1'b1, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"123456789",    1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"123456789x",   1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"12345678.5",   1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"1.2345",       1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"1.23x",        1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"-0.07",        1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"-5",           1'b0, 1'b1, 35'sd0,           dhp_pkg::STATUS_NO_MINUS},
      '{"-x9",          1'b0, 1'b1, 35'sd0,           dhp_pkg::STATUS_NO_MINUS},
      '{"-",            1'b0, 1'b1, 35'sd0,           dhp_pkg::STATUS_NO_MINUS},
      '{"5-",           1'b0, 1'b1, 35'sd0,           dhp_pkg::STATUS_BAD_CHAR},
      '{"25.5",         1'b0, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK},
      '{"-3.1",         1'b1, 1'b0, 35'sd0,           dhp_pkg::STATUS_OK}
   };

   // Prints one line per mismatch and counts it.
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   // Advances the predicted parse by one accepted byte. A terminator yields the result
   // and returns the parse to its starting state.
   task automatic parse_byte(input logic [7:0] c, output bit done,
                             output parse_result_type res);
      logic [dhp_pkg::ACC_WIDTH-1:0] scaled;
      int                            pad;
      bit                            is_digit;
      is_digit = (c >= dhp_pkg::CHAR_ZERO) && (c <= dhp_pkg::CHAR_NINE);
      done = 1'b0;
      res = '0;
      if (c == dhp_pkg::CHAR_TERM) begin
         done = 1'b1;
         res.status = p_error;
         if (p_error == dhp_pkg::STATUS_OK) begin
            // Missing fraction digits are made up by scaling; before the point all of them
            // are missing, and skipping after the integer limit also cleared the count.
            pad = FRAC_LIMIT;
            if (p_phase == dhp_pkg::PH_FRAC || p_phase == dhp_pkg::PH_SKIP) begin
               pad = (p_count < FRAC_LIMIT) ? FRAC_LIMIT - p_count : 0;
            end
            scaled = p_acc;
            repeat (pad) scaled = scaled * 10;
            res.value = p_negative ? 35'd0 - {1'b0, scaled} : {1'b0, scaled};
         end
         p_phase    = dhp_pkg::PH_START;
         p_acc      = '0;
         p_count    = '0;
         p_negative = 1'b0;
         p_error    = dhp_pkg::STATUS_OK;
         return;
      end
      if (p_phase == dhp_pkg::PH_START) begin
         if (c == dhp_pkg::CHAR_MINUS) begin
            if (negatives_allowed) begin
               p_negative = 1'b1;
               p_phase    = dhp_pkg::PH_INT;
            end else begin
               p_phase = dhp_pkg::PH_ERROR;
               p_error = dhp_pkg::STATUS_NO_MINUS;
            end
            return;
         end
         p_phase = dhp_pkg::PH_INT;
      end
      case (p_phase)
         dhp_pkg::PH_INT: begin
            if (c == dhp_pkg::CHAR_POINT) begin
               p_phase = dhp_pkg::PH_FRAC;
               p_count = '0;
            end else if (p_count >= INT_LIMIT) begin
               p_phase = dhp_pkg::PH_SKIP;
               p_count = '0;
            end else if (is_digit) begin
               p_acc   = p_acc * 10 + (c - dhp_pkg::CHAR_ZERO);
               p_count = p_count + 1'b1;
            end else begin
               p_phase = dhp_pkg::PH_ERROR;
               p_error = dhp_pkg::STATUS_BAD_CHAR;
            end
         end
         dhp_pkg::PH_FRAC: begin
            if (p_count >= FRAC_LIMIT) begin
               p_phase = dhp_pkg::PH_SKIP;
            end else if (is_digit) begin
               p_acc   = p_acc * 10 + (c - dhp_pkg::CHAR_ZERO);
               p_count = p_count + 1'b1;
            end else begin
               p_phase = dhp_pkg::PH_ERROR;
               p_error = dhp_pkg::STATUS_BAD_CHAR;
            end
         end
         default: begin
         end
      endcase
   endtask

   // Compares one accepted result beat with the oldest expectation.
   task automatic check_result(input logic signed [dhp_pkg::VALUE_WIDTH-1:0] value,
                               input logic [dhp_pkg::STATUS_WIDTH-1:0] status);
      parse_result_type want;
      if (pending_results.size() == 0) begin
         flag_mismatch($sformatf("unexpected result beat, value %0d status %0d",
                                 value, status));
         return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
         flag_mismatch($sformatf("value %0d, expected %0d", value, want.value));
      end
      if (status !== want.status) begin
         flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
   endtask

   // Sends text_bytes one beat at a time. Every accepted byte goes through the predictor;
   // a terminator queues either the predicted result or, for a typed row, the given one.
   task automatic send_text(input bit typed, input parse_result_type typed_result);
      int unsigned      gap;
      bit               done;
      parse_result_type got;
      foreach (text_bytes[i]) begin
         gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, MAX_GAP);
         // Valid only drops when a gap is wanted, so a back-to-back beat keeps it high.
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_text_byte <= text_bytes[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         parse_byte(text_bytes[i], done, got);
         if (done) begin
            pending_results.push_back(typed ? typed_result : got);
         end
         sent_bytes++;
      end
   endtask

   // Stops offering bytes and waits until every owed result is out and the block is quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes allow_negative while the block is idle and mirrors it in the predictor.
   task automatic write_allow_negative(input bit allow);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= allow;
      @(posedge clock);
      negatives_allowed = allow;
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] random_digit();
      return dhp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // A character that may break an otherwise well-formed text: a minus, a point or any nonzero byte.
   function automatic logic [7:0] random_noise();
      case ($urandom_range(0, 2))
         0:       return dhp_pkg::CHAR_MINUS;
         1:       return dhp_pkg::CHAR_POINT;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Fills text_bytes with a random text. Most are well-formed with random digit counts
   // on both sides of the limits; the rest are broken texts, pure noise, or a few digits
   // with no terminator that run on into the next text.
   task automatic build_random_text();
      int unsigned kind;
      int unsigned n;
      kind = $urandom_range(0, 15);
      text_bytes.delete();
      if (kind < 11) begin
         if ($urandom_range(0, 2) == 0) text_bytes.push_back(dhp_pkg::CHAR_MINUS);
         n = $urandom_range(0, INT_LIMIT + 2);
         repeat (n) text_bytes.push_back(random_digit());
         if (kind == 9) text_bytes.push_back(random_noise());
         if ($urandom_range(0, 2) != 0) begin
            text_bytes.push_back(dhp_pkg::CHAR_POINT);
            n = $urandom_range(0, FRAC_LIMIT + 2);
            repeat (n) text_bytes.push_back(random_digit());
         end
         if (kind == 10) text_bytes.push_back(random_noise());
      end else if (kind < 15) begin
         n = $urandom_range(0, 6);
         repeat (n) text_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) text_bytes.push_back(random_digit());
         return;
      end
      text_bytes.push_back(dhp_pkg::CHAR_TERM);
   endtask

   // Receiver: checks every accepted result beat, then stalls for a drawn number of
   // cycles. Quiet stretches come from the calm flag, and a pending hold request turns
   // into one long stall so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_value_hundredths, rsp_status);
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            sink_wait = LONG_HOLD_CYCLES;
         end else if (rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
            sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (sink_wait != 0) begin
            rsp_stall <= 1'b1;
            sink_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // The cycle counter ends a run that hangs.
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("decimal_hundredths_parser verification failed");
      $finish;
   end

   initial begin : stimulus
      int               len;
      int unsigned      phase_end;
      parse_result_type row_want;

      // Reset is held at the start and never asserted again.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The register is written before the first row and wherever a row
      // asks for the other setting, always with the block idle.
      foreach (directed_cases[i]) begin
         if (i == 0 || directed_cases[i].allow_minus != negatives_allowed) begin
            write_allow_negative(directed_cases[i].allow_minus);
         end
         text_bytes.delete();
         len = 0;
         while (len < TEXT_CHARS && directed_cases[i].text[8*len +: 8] != dhp_pkg::CHAR_TERM)
            len++;
         for (int k = len - 1; k >= 0; k--) begin
            text_bytes.push_back(directed_cases[i].text[8*k +: 8]);
         end
         text_bytes.push_back(dhp_pkg::CHAR_TERM);
         row_want.value  = directed_cases[i].value;
         row_want.status = directed_cases[i].status;
         tx_calm = ($urandom_range(0, 3) == 0);
         send_text(directed_cases[i].typed, row_want);
      end

      // Random part, in phases. The first four alternate the register between its two
      // values; later phases draw it. Each phase begins with the block idle.
      sent_bytes = 0;
      for (int phase_index = 0; phase_index < 8; phase_index++) begin
         if (phase_index < 4) begin
            write_allow_negative(phase_index % 2 == 1);
         end else begin
            write_allow_negative(1'($urandom_range(0, 1)));
         end
         phase_end = PHASE_BYTES * (phase_index + 1);

         // Long receiver hold: short terminated texts go out back to back, so a result
         // waits in the output register, the next terminator blocks the input register
         // and the block stalls its input.
         if (phase_index == 2) begin
            hold_requests++;
            tx_rush = 1'b1;
            repeat (10) begin
               text_bytes.delete();
               text_bytes.push_back(random_digit());
               text_bytes.push_back(dhp_pkg::CHAR_TERM);
               send_text(1'b0, '0);
            end
            tx_rush = 1'b0;
         end

         while (sent_bytes < phase_end) begin
            if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
            build_random_text();
            send_text(1'b0, '0);
            // Halfway through one phase the sender pauses until every result has come.
            if (phase_index == 5 && sent_bytes >= phase_end - PHASE_BYTES / 2
                && sent_bytes < phase_end - PHASE_BYTES / 2 + 16) begin
               settle_block();
            end
         end
      end

      // Drain: wait for the last results, then wait on for anything unexpected.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("decimal_hundredths_parser verification clean");
      end else begin
         $display("decimal_hundredths_parser verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/dhp_pkg.sv
hdl/dhp_step.sv
hdl/decimal_hundredths_parser.sv
tb/sv/tb_decimal_hundredths_parser.sv
